>>> hdl/i2c_mra_pkg.sv
// Shared types and constants for the I2C master register access block.
package i2c_mra_pkg;

    localparam int unsigned PHASE_W   = 5;
    localparam int unsigned TMO_REG_W = 10;

    localparam logic [TMO_REG_W-1:0] ACK_TIMEOUT_RST = 10'd100;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_DATA  = 2'd3;

    localparam logic [PHASE_W-1:0] PH_IDLE     = 5'd0;
    localparam logic [PHASE_W-1:0] PH_START    = 5'd1;
    localparam logic [PHASE_W-1:0] PH_TX_DEV   = 5'd2;
    localparam logic [PHASE_W-1:0] PH_ACK_DEV  = 5'd3;
    localparam logic [PHASE_W-1:0] PH_TX_REG   = 5'd4;
    localparam logic [PHASE_W-1:0] PH_ACK_REG  = 5'd5;
    localparam logic [PHASE_W-1:0] PH_NEED     = 5'd6;
    localparam logic [PHASE_W-1:0] PH_TX_DATA  = 5'd7;
    localparam logic [PHASE_W-1:0] PH_ACK_DATA = 5'd8;
    localparam logic [PHASE_W-1:0] PH_RSTART   = 5'd9;
    localparam logic [PHASE_W-1:0] PH_TX_DEVR  = 5'd10;
    localparam logic [PHASE_W-1:0] PH_ACK_DEVR = 5'd11;
    localparam logic [PHASE_W-1:0] PH_RX       = 5'd12;
    localparam logic [PHASE_W-1:0] PH_MACK     = 5'd13;
    localparam logic [PHASE_W-1:0] PH_STOP     = 5'd14;
    localparam logic [PHASE_W-1:0] PH_STOP_ERR = 5'd15;

    localparam logic [7:0] MSB_MASK = 8'h80;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       need_data;
        logic       rd_valid;
        logic [7:0] rd_data;
        logic       rd_last;
        logic       done_res;
        logic       error;
    } t_result;

endpackage

>>> hdl/i2c_mra_ctrl.sv
// Transaction sequencer: bus phase state, bit timing and per-request result logic.
module i2c_mra_ctrl #(
    parameter int unsigned COUNT_BITS   = 16,
    parameter int unsigned TIMEOUT_BITS = 10
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [i2c_mra_pkg::TMO_REG_W-1:0] i_cfg_data,
    input  logic                             i_accept,
    input  logic [1:0]                       i_req_type,
    input  logic [6:0]                       i_dev_addr,
    input  logic [7:0]                       i_mem_addr,
    input  logic [15:0]                      i_byte_count,
    input  logic [7:0]                       i_wr_data,
    input  logic                             i_sda_in,
    output i2c_mra_pkg::t_result             o_result
);
    import i2c_mra_pkg::*;

    localparam int unsigned CMP_W = (TIMEOUT_BITS > TMO_REG_W) ? TIMEOUT_BITS : TMO_REG_W;

    logic [TMO_REG_W-1:0]    r_ack_timeout;
    logic [PHASE_W-1:0]      r_phase, n_phase;
    logic [1:0]              r_tick, n_tick;
    logic [2:0]              r_bit, n_bit;
    logic [7:0]              r_shift, n_shift;
    logic [COUNT_BITS-1:0]   r_left, n_left;
    logic [TIMEOUT_BITS-1:0] r_wait, n_wait;
    logic [6:0]              r_dev, n_dev;
    logic [7:0]              r_reg, n_reg;
    logic                    r_read, n_read;

    logic                  scl, sdo, rv, rl, done, err;
    logic [7:0]            rd;
    logic                  last_bit, one_left;
    logic [COUNT_BITS-1:0] left_dec;
    logic [CMP_W-1:0]      wait_ext, tmo_ext;
    logic [7:0]            rx_byte;

    always_comb begin
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_left   = r_left;
        n_wait   = r_wait;
        n_dev    = r_dev;
        n_reg    = r_reg;
        n_read   = r_read;
        scl      = 1'b1;
        sdo      = 1'b1;
        rv       = 1'b0;
        rd       = '0;
        rl       = 1'b0;
        done     = 1'b0;
        err      = 1'b0;
        last_bit = (r_bit == 3'd7);
        one_left = (r_left == COUNT_BITS'(1));
        left_dec = r_left - COUNT_BITS'(1);
        wait_ext = CMP_W'(r_wait);
        tmo_ext  = CMP_W'(r_ack_timeout);
        rx_byte  = {r_shift[6:0], i_sda_in};

        unique case (r_phase)
            PH_IDLE: begin
                if (i_req_type == REQ_WRITE || i_req_type == REQ_READ) begin
                    n_dev   = i_dev_addr;
                    n_reg   = i_mem_addr;
                    n_left  = i_byte_count[COUNT_BITS-1:0];
                    n_read  = (i_req_type == REQ_READ);
                    n_phase = PH_START;
                    n_tick  = '0;
                    n_bit   = '0;
                    n_wait  = '0;
                end
            end
            PH_START, PH_RSTART: begin
                scl = (r_tick == 2'd1) || (r_tick == 2'd2);
                sdo = (r_tick <= 2'd1);
                if (r_tick == 2'd3) begin
                    n_shift = {r_dev, (r_phase == PH_RSTART)};
                    n_phase = (r_phase == PH_RSTART) ? PH_TX_DEVR : PH_TX_DEV;
                    n_tick  = '0;
                    n_bit   = '0;
                    n_wait  = '0;
                end else begin
                    n_tick = r_tick + 2'd1;
                end
            end
            PH_TX_DEV, PH_TX_REG, PH_TX_DATA, PH_TX_DEVR: begin
                scl = (r_tick == 2'd1) || (r_tick == 2'd2);
                sdo = |(r_shift & MSB_MASK);
                if (r_tick == 2'd3) begin
                    n_shift = {r_shift[6:0], 1'b0};
                    n_tick  = '0;
                    if (last_bit) begin
                        n_phase = r_phase + PHASE_W'(1);
                        n_bit   = '0;
                        n_wait  = '0;
                    end else begin
                        n_bit = r_bit + 3'd1;
                    end
                end else begin
                    n_tick = r_tick + 2'd1;
                end
            end
            PH_ACK_DEV, PH_ACK_REG, PH_ACK_DATA, PH_ACK_DEVR: begin
                if (r_tick == 2'd0) begin
                    scl    = 1'b0;
                    n_tick = 2'd1;
                end else if (r_tick == 2'd1) begin
                    n_tick = 2'd2;
                end else if (!i_sda_in) begin
                    n_tick = '0;
                    n_bit  = '0;
                    n_wait = '0;
                    unique case (r_phase)
                        PH_ACK_DEV: begin
                            n_shift = r_reg;
                            n_phase = PH_TX_REG;
                        end
                        PH_ACK_REG: begin
                            if (r_read) begin
                                n_phase = PH_RSTART;
                            end else begin
                                n_phase = (r_left == '0) ? PH_STOP : PH_NEED;
                            end
                        end
                        PH_ACK_DATA: begin
                            n_left  = left_dec;
                            n_phase = (left_dec == '0) ? PH_STOP : PH_NEED;
                        end
                        default: begin
                            n_shift = '0;
                            n_phase = (r_left == '0) ? PH_STOP : PH_RX;
                        end
                    endcase
                end else if (wait_ext >= tmo_ext || (&r_wait)) begin
                    n_phase = PH_STOP_ERR;
                    n_tick  = '0;
                    n_bit   = '0;
                    n_wait  = '0;
                end else begin
                    n_wait = r_wait + TIMEOUT_BITS'(1);
                end
            end
            PH_NEED: begin
                scl = 1'b0;
                if (i_req_type == REQ_DATA) begin
                    n_shift = i_wr_data;
                    n_phase = PH_TX_DATA;
                    n_tick  = '0;
                    n_bit   = '0;
                    n_wait  = '0;
                end
            end
            PH_RX: begin
                scl = (r_tick == 2'd1) || (r_tick == 2'd2);
                if (r_tick == 2'd2) begin
                    n_shift = rx_byte;
                    if (last_bit) begin
                        rv = 1'b1;
                        rd = rx_byte;
                        rl = one_left;
                    end
                end
                if (r_tick == 2'd3) begin
                    n_tick = '0;
                    if (last_bit) begin
                        n_phase = PH_MACK;
                        n_bit   = '0;
                        n_wait  = '0;
                    end else begin
                        n_bit = r_bit + 3'd1;
                    end
                end else begin
                    n_tick = r_tick + 2'd1;
                end
            end
            PH_MACK: begin
                scl = (r_tick == 2'd1) || (r_tick == 2'd2);
                sdo = one_left;
                if (r_tick == 2'd3) begin
                    n_left  = left_dec;
                    n_shift = '0;
                    n_phase = (left_dec == '0) ? PH_STOP : PH_RX;
                    n_tick  = '0;
                    n_bit   = '0;
                    n_wait  = '0;
                end else begin
                    n_tick = r_tick + 2'd1;
                end
            end
            PH_STOP, PH_STOP_ERR: begin
                scl = (r_tick >= 2'd1);
                sdo = (r_tick >= 2'd2);
                if (r_tick >= 2'd2) begin
                    done    = 1'b1;
                    err     = (r_phase == PH_STOP_ERR);
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                    n_bit   = '0;
                    n_wait  = '0;
                end else begin
                    n_tick = r_tick + 2'd1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_tick  = '0;
                n_bit   = '0;
                n_wait  = '0;
            end
        endcase
    end

    always_comb begin
        o_result.scl_out   = scl;
        o_result.sda_out   = sdo;
        o_result.busy_res  = (n_phase != PH_IDLE);
        o_result.need_data = (n_phase == PH_NEED);
        o_result.rd_valid  = rv;
        o_result.rd_data   = rd;
        o_result.rd_last   = rl;
        o_result.done_res  = done;
        o_result.error     = err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= ACK_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            r_ack_timeout <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_bit   <= '0;
            r_shift <= '0;
            r_left  <= '0;
            r_wait  <= '0;
            r_dev   <= '0;
            r_reg   <= '0;
            r_read  <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_left  <= n_left;
            r_wait  <= n_wait;
            r_dev   <= n_dev;
            r_reg   <= n_reg;
            r_read  <= n_read;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_tick == 2'd0 && r_bit == 3'd0 && r_wait == '0))
        else $error("idle phase with timing counters not cleared");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wait != '0) |-> (r_phase == PH_ACK_DEV || r_phase == PH_ACK_REG ||
                            r_phase == PH_ACK_DATA || r_phase == PH_ACK_DEVR))
        else $error("ack wait count running outside an ack phase");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_NEED || r_phase == PH_RX || r_phase == PH_MACK) |-> (r_left != '0))
        else $error("byte phase entered with no bytes left");

endmodule

>>> hdl/i2c_mra_outbuf.sv
// Result register with one skid entry, so one further request is taken under output stall.
module i2c_mra_outbuf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  i2c_mra_pkg::t_result i_result,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output i2c_mra_pkg::t_result o_result
);
    import i2c_mra_pkg::*;

    logic    r_out_v, r_skid_v;
    t_result r_out, r_skid;
    logic    accept, out_ready;

    assign o_in_stall  = r_skid_v;
    assign accept      = i_in_valid && !r_skid_v;
    assign out_ready   = !r_out_v || !i_out_stall;
    assign o_out_valid = r_out_v;
    assign o_result    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_ready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= accept;
            end
        end else if (accept) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready) begin
            if (r_skid_v) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= i_result;
            end
        end else if (accept) begin
            r_skid <= i_result;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held while result register empty");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && (r_out.rd_last || r_out.rd_data != 8'd0)) |-> r_out.rd_valid)
        else $error("read data present without read valid");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.error) |-> (r_out.done_res && !r_out.busy_res))
        else $error("error flagged outside transaction end");

endmodule

>>> hdl/i2c_master_register_access_core.sv
// Top level of the I2C master register access block.
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request per accepted
//   edge: a bus timing tick, a begin-write or begin-read command, or a write
//   byte, together with the sampled SDA level.
//   Output channel (o_out_valid / i_out_stall) returns exactly one result per
//   request: SCL/SDA levels to drive, busy, need_data, received byte with
//   valid/last flags, done and error.
//   Each sent or received bit spans four requests (SCL low, high, high, low).
//   Results are registered: in the result register, or in the skid entry.
//   Throughput: one request per cycle while o_in_stall is low; the sequencer
//   state updates in a single pass between the state registers and the result register.
//   When the receiver stalls, one further request is taken into a skid
//   entry; o_in_stall then rises until the result register drains.
//   i_cfg_we writes the ACK timeout register; write it only when idle.
//   Reset (synchronous, active low) returns the bus to idle, clears both
//   result entries and sets the ACK timeout to 100 ticks.
module i2c_master_register_access_core #(
    parameter int unsigned COUNT_BITS   = 16,
    parameter int unsigned TIMEOUT_BITS = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [i2c_mra_pkg::TMO_REG_W-1:0] i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_req_type,
    input  logic [6:0]                        i_dev_addr,
    input  logic [7:0]                        i_mem_addr,
    input  logic [15:0]                       i_byte_count,
    input  logic [7:0]                        i_wr_data,
    input  logic                              i_sda_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_scl_out,
    output logic                              o_sda_out,
    output logic                              o_busy_res,
    output logic                              o_need_data,
    output logic                              o_rd_valid,
    output logic [7:0]                        o_rd_data,
    output logic                              o_rd_last,
    output logic                              o_done_res,
    output logic                              o_error
);
    import i2c_mra_pkg::*;

    t_result step_res, out_res;
    logic    accept;

    assign accept = i_in_valid && !o_in_stall;

    i2c_mra_ctrl #(
        .COUNT_BITS   (COUNT_BITS),
        .TIMEOUT_BITS (TIMEOUT_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_req_type   (i_req_type),
        .i_dev_addr   (i_dev_addr),
        .i_mem_addr   (i_mem_addr),
        .i_byte_count (i_byte_count),
        .i_wr_data    (i_wr_data),
        .i_sda_in     (i_sda_in),
        .o_result     (step_res)
    );

    i2c_mra_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_result    (step_res),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (out_res)
    );

    assign o_scl_out   = out_res.scl_out;
    assign o_sda_out   = out_res.sda_out;
    assign o_busy_res  = out_res.busy_res;
    assign o_need_data = out_res.need_data;
    assign o_rd_valid  = out_res.rd_valid;
    assign o_rd_data   = out_res.rd_data;
    assign o_rd_last   = out_res.rd_last;
    assign o_done_res  = out_res.done_res;
    assign o_error     = out_res.error;

endmodule

>>> tb/i2c_master_register_access_core_tb.sv
// Self-checking testbench for the I2C master register access core.
module i2c_master_register_access_core_tb;
    import i2c_mra_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 60;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [6:0]  dev_addr;
        logic [7:0]  mem_addr;
        logic [15:0] byte_count;
        logic [7:0]  wr_data;
        logic        sda_in;
    } t_request;

    class i2c_line_scoreboard;
        logic [PHASE_W-1:0]   phase;
        logic [1:0]           tick_ph;
        logic [2:0]           bit_idx;
        logic [7:0]           shift_q;
        logic [15:0]          bytes_left;
        logic [TMO_REG_W-1:0] wait_cnt;
        logic [TMO_REG_W-1:0] ack_timeout;
        logic [6:0]           dev_q;
        logic [7:0]           mem_q;
        logic                 rd_mode;
        t_result              expected_levels[$];
        int                   errors;
        int                   n_done;
        int                   n_abort;
        int                   n_rx;

        function new();
            phase       = PH_IDLE;
            tick_ph     = '0;
            bit_idx     = '0;
            shift_q     = '0;
            bytes_left  = '0;
            wait_cnt    = '0;
            ack_timeout = ACK_TIMEOUT_RST;
            dev_q       = '0;
            mem_q       = '0;
            rd_mode     = 1'b0;
            errors      = 0;
            n_done      = 0;
            n_abort     = 0;
            n_rx        = 0;
        endfunction

        function void enter_phase(logic [PHASE_W-1:0] ph);
            phase    = ph;
            tick_ph  = '0;
            bit_idx  = '0;
            wait_cnt = '0;
        endfunction

        function void ack_seen();
            case (phase)
                PH_ACK_DEV: begin
                    shift_q = mem_q;
                    enter_phase(PH_TX_REG);
                end
                PH_ACK_REG: begin
                    if (rd_mode)
                        enter_phase(PH_RSTART);
                    else
                        enter_phase(bytes_left == 0 ? PH_STOP : PH_NEED);
                end
                PH_ACK_DATA: begin
                    bytes_left = bytes_left - 16'd1;
                    enter_phase(bytes_left == 0 ? PH_STOP : PH_NEED);
                end
                default: begin
                    shift_q = '0;
                    enter_phase(bytes_left == 0 ? PH_STOP : PH_RX);
                end
            endcase
        endfunction

        function t_result next_levels(t_request r);
            t_result    res;
            logic [1:0] t;
            res         = '0;
            res.scl_out = 1'b1;
            res.sda_out = 1'b1;
            t           = tick_ph;
            case (phase)
                PH_IDLE: begin
                    if (r.req_type == REQ_WRITE || r.req_type == REQ_READ) begin
                        dev_q      = r.dev_addr;
                        mem_q      = r.mem_addr;
                        bytes_left = r.byte_count;
                        rd_mode    = (r.req_type == REQ_READ);
                        enter_phase(PH_START);
                    end
                end
                PH_START, PH_RSTART: begin
                    res.scl_out = (t == 2'd1 || t == 2'd2);
                    res.sda_out = (t <= 2'd1);
                    if (t == 2'd3) begin
                        shift_q = {dev_q, phase == PH_RSTART};
                        enter_phase(phase == PH_RSTART ? PH_TX_DEVR : PH_TX_DEV);
                    end else begin
                        tick_ph = t + 2'd1;
                    end
                end
                PH_TX_DEV, PH_TX_REG, PH_TX_DATA, PH_TX_DEVR: begin
                    res.scl_out = (t == 2'd1 || t == 2'd2);
                    res.sda_out = shift_q[7];
                    if (t == 2'd3) begin
                        shift_q = shift_q << 1;
                        if (bit_idx == 3'd7) begin
                            enter_phase(phase + 1'b1);
                        end else begin
                            bit_idx = bit_idx + 3'd1;
                            tick_ph = '0;
                        end
                    end else begin
                        tick_ph = t + 2'd1;
                    end
                end
                PH_ACK_DEV, PH_ACK_REG, PH_ACK_DATA, PH_ACK_DEVR: begin
                    if (t == 2'd0) begin
                        res.scl_out = 1'b0;
                        tick_ph     = 2'd1;
                    end else if (t == 2'd1) begin
                        tick_ph = 2'd2;
                    end else if (!r.sda_in) begin
                        ack_seen();
                    end else if (wait_cnt >= ack_timeout || wait_cnt == '1) begin
                        enter_phase(PH_STOP_ERR);
                    end else begin
                        wait_cnt = wait_cnt + 1'b1;
                    end
                end
                PH_NEED: begin
                    res.scl_out = 1'b0;
                    if (r.req_type == REQ_DATA) begin
                        shift_q = r.wr_data;
                        enter_phase(PH_TX_DATA);
                    end
                end
                PH_RX: begin
                    res.scl_out = (t == 2'd1 || t == 2'd2);
                    if (t == 2'd2) begin
                        shift_q = {shift_q[6:0], r.sda_in};
                        if (bit_idx == 3'd7) begin
                            res.rd_valid = 1'b1;
                            res.rd_data  = shift_q;
                            res.rd_last  = (bytes_left == 16'd1);
                            n_rx++;
                        end
                    end
                    if (t == 2'd3) begin
                        if (bit_idx == 3'd7) begin
                            enter_phase(PH_MACK);
                        end else begin
                            bit_idx = bit_idx + 3'd1;
                            tick_ph = '0;
                        end
                    end else begin
                        tick_ph = t + 2'd1;
                    end
                end
                PH_MACK: begin
                    res.scl_out = (t == 2'd1 || t == 2'd2);
                    res.sda_out = (bytes_left == 16'd1);
                    if (t == 2'd3) begin
                        bytes_left = bytes_left - 16'd1;
                        shift_q    = '0;
                        enter_phase(bytes_left == 0 ? PH_STOP : PH_RX);
                    end else begin
                        tick_ph = t + 2'd1;
                    end
                end
                PH_STOP, PH_STOP_ERR: begin
                    res.scl_out = (t >= 2'd1);
                    res.sda_out = (t >= 2'd2);
                    if (t >= 2'd2) begin
                        res.done_res = 1'b1;
                        res.error    = (phase == PH_STOP_ERR);
                        n_done++;
                        if (res.error)
                            n_abort++;
                        enter_phase(PH_IDLE);
                    end else begin
                        tick_ph = t + 2'd1;
                    end
                end
                default: enter_phase(PH_IDLE);
            endcase
            res.busy_res  = (phase != PH_IDLE);
            res.need_data = (phase == PH_NEED);
            return res;
        endfunction

        function void note_request(t_request r);
            expected_levels.push_back(next_levels(r));
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction

        function void compare_field(string name, logic [7:0] e, logic [7:0] a);
            if (a !== e) begin
                if (errors < 100)
                    $display("%0t: %s expected %0h, got %0h", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_result(t_result act);
            t_result e;
            if (expected_levels.size() == 0) begin
                $display("%0t: result with no request pending, got %h", $time, act);
                errors++;
                return;
            end
            e = expected_levels.pop_front();
            compare_field("scl_out", 8'(e.scl_out), 8'(act.scl_out));
            compare_field("sda_out", 8'(e.sda_out), 8'(act.sda_out));
            compare_field("busy_res", 8'(e.busy_res), 8'(act.busy_res));
            compare_field("need_data", 8'(e.need_data), 8'(act.need_data));
            compare_field("rd_valid", 8'(e.rd_valid), 8'(act.rd_valid));
            compare_field("rd_data", e.rd_data, act.rd_data);
            compare_field("rd_last", 8'(e.rd_last), 8'(act.rd_last));
            compare_field("done_res", 8'(e.done_res), 8'(act.done_res));
            compare_field("error", 8'(e.error), 8'(act.error));
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [TMO_REG_W-1:0] i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_request             req_q;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_scl_out;
    logic                 o_sda_out;
    logic                 o_busy_res;
    logic                 o_need_data;
    logic                 o_rd_valid;
    logic [7:0]           o_rd_data;
    logic                 o_rd_last;
    logic                 o_done_res;
    logic                 o_error;

    i2c_line_scoreboard sb = new();

    int n_acc     = 0;
    int cycles    = 0;
    int src_pct   = 22;
    int snk_pct   = 49;
    int hold_req  = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int tmo_a;
    int tmo_b;
    int tmo_c;

    i2c_master_register_access_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (req_q.req_type),
        .i_dev_addr  (req_q.dev_addr),
        .i_mem_addr  (req_q.mem_addr),
        .i_byte_count(req_q.byte_count),
        .i_wr_data   (req_q.wr_data),
        .i_sda_in    (req_q.sda_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_scl_out   (o_scl_out),
        .o_sda_out   (o_sda_out),
        .o_busy_res  (o_busy_res),
        .o_need_data (o_need_data),
        .o_rd_valid  (o_rd_valid),
        .o_rd_data   (o_rd_data),
        .o_rd_last   (o_rd_last),
        .o_done_res  (o_done_res),
        .o_error     (o_error)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: no finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("** i2c_master_register_access_core: FAILED **");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < snk_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                sb.check_result({o_scl_out, o_sda_out, o_busy_res, o_need_data, o_rd_valid,
                                 o_rd_data, o_rd_last, o_done_res, o_error});
            if (i_in_valid && !o_in_stall) begin
                sb.note_request(req_q);
                n_acc++;
            end
        end
    end

    function automatic t_request rand_request();
        t_request r;
        r.req_type   = REQ_TICK;
        r.dev_addr   = 7'($urandom());
        r.mem_addr   = 8'($urandom());
        r.byte_count = 16'($urandom());
        r.wr_data    = 8'($urandom());
        r.sda_in     = 1'($urandom_range(1));
        return r;
    endfunction

    // number of high SDA samples before the slave acknowledges
    function automatic int ack_delay();
        int p;
        p = $urandom_range(99);
        if (sb.ack_timeout <= 16) begin
            if (p < 70)
                return 0;
            if (p < 85)
                return $urandom_range(1, 2);
            if (p < 95)
                return int'(sb.ack_timeout);
            return int'(sb.ack_timeout) + 1;
        end
        return (p < 80) ? 0 : $urandom_range(1, 3);
    endfunction

    task automatic push_req(input t_request r);
        int target;
        while ($urandom_range(99) < src_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        req_q      <= r;
        target = n_acc + 1;
        wait (n_acc == target);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [TMO_REG_W-1:0] v);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.ack_timeout = v;
    endtask

    task automatic idle_chatter(input int n);
        t_request r;
        for (int i = 0; i < n; i++) begin
            r = rand_request();
            if ($urandom_range(1))
                r.req_type = REQ_DATA;
            push_req(r);
        end
    endtask

    // nack_at: index of the ACK wait that never gets an ACK, -1 for none
    task automatic run_transfer(input logic [1:0] kind, input logic [6:0] dev,
                                input logic [7:0] mem, input logic [15:0] cnt,
                                input int nack_at, input bit clean);
        t_request r;
        int       ack_idx;
        int       high_left;
        int       n_data;
        int       k;
        ack_idx   = 0;
        high_left = 0;
        n_data    = 0;
        r = rand_request();
        r.req_type   = kind;
        r.dev_addr   = dev;
        r.mem_addr   = mem;
        r.byte_count = cnt;
        push_req(r);
        while (sb.phase != PH_IDLE) begin
            r = rand_request();
            if (sb.phase == PH_NEED) begin
                k = $urandom_range(7);
                if (k == 2) begin
                    r.req_type = REQ_READ;
                end else if (k > 2) begin
                    r.req_type = REQ_DATA;
                    if (clean)
                        r.wr_data = {8{n_data[0]}};
                    n_data++;
                end
            end else begin
                if ($urandom_range(24) == 0)
                    r.req_type = 2'($urandom_range(1, 3));
                if (sb.phase inside {PH_ACK_DEV, PH_ACK_REG, PH_ACK_DATA, PH_ACK_DEVR} &&
                    sb.tick_ph >= 2'd2) begin
                    if (sb.wait_cnt == 0) begin
                        high_left = (ack_idx == nack_at) ? 4096 : (clean ? 0 : ack_delay());
                        ack_idx++;
                    end
                    r.sda_in = (high_left != 0);
                    if (high_left != 0)
                        high_left--;
                end
            end
            push_req(r);
        end
    endtask

    task automatic random_transfer();
        logic [1:0]  kind;
        logic [15:0] cnt;
        int          nack_at;
        kind    = $urandom_range(1) ? REQ_READ : REQ_WRITE;
        cnt     = 16'($urandom_range(0, 3));
        nack_at = -1;
        case ($urandom_range(9))
            0: begin
                if (kind == REQ_WRITE) begin
                    cnt     = 16'($urandom());
                    nack_at = $urandom_range(2, 4);
                end else begin
                    cnt = 16'($urandom_range(4, 6));
                end
            end
            1: nack_at = $urandom_range(0, 2);
            default: ;
        endcase
        run_transfer(kind, 7'($urandom()), 8'($urandom()), cnt, nack_at, 1'b0);
    endtask

    task automatic random_phase(input int src, input int snk, input int tmo,
                                input int n_items, input bit squeeze);
        int stop_at;
        write_timeout(TMO_REG_W'(tmo));
        src_pct = src;
        snk_pct = snk;
        if (squeeze)
            hold_req++;
        stop_at = n_acc + n_items;
        while (n_acc < stop_at) begin
            random_transfer();
            if ($urandom_range(3) == 0)
                idle_chatter($urandom_range(1, 4));
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        req_q      <= '0;
        tmo_a = $urandom_range(1, 6);
        tmo_b = $urandom_range(7, 16);
        tmo_c = $urandom_range(2, 16);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, zero length, stray data, a two-byte read
        idle_chatter(3);
        run_transfer(REQ_WRITE, 7'h7F, 8'hFF, 16'd0, -1, 1'b1);
        run_transfer(REQ_READ, 7'h00, 8'h00, 16'd0, -1, 1'b1);
        run_transfer(REQ_READ, 7'h55, 8'hAA, 16'd2, -1, 1'b1);

        // ACK timeouts with zero tolerance
        write_timeout('0);
        run_transfer(REQ_WRITE, 7'h13, 8'h31, 16'hFFFF, 3, 1'b1);
        run_transfer(REQ_READ, 7'h61, 8'h16, 16'd1, 0, 1'b1);

        random_phase(22, 49, tmo_a, 80, 1'b0);
        random_phase(49, 22, tmo_b, 80, 1'b0);
        random_phase(0, 0, tmo_c, 80, 1'b1);

        settle();
        repeat (4) @(posedge i_clk);
        $display("%0d requests, %0d transfers done, %0d aborted on ACK timeout, %0d bytes read",
                 n_acc, sb.n_done, sb.n_abort, sb.n_rx);
        $display("ACK timeout settings used: 100, 0, %0d, %0d, %0d", tmo_a, tmo_b, tmo_c);
        if (sb.errors == 0)
            $display("** i2c_master_register_access_core: PASSED **");
        else
            $display("** i2c_master_register_access_core: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
hdl/i2c_mra_pkg.sv
hdl/i2c_mra_ctrl.sv
hdl/i2c_mra_outbuf.sv
hdl/i2c_master_register_access_core.sv
tb/i2c_master_register_access_core_tb.sv
